// ===== sv/median_filter_2d_defines.svh =====
// assertion macros used by the median filter top level
`ifndef MEDIAN_FILTER_2D_DEFINES_SVH
`define MEDIAN_FILTER_2D_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MF_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("median filter check failed");

// next-cycle implication, sampled on clk, off during reset
`define MF_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("median filter check failed");

`endif

// ===== sv/mf2d_pkg.sv =====
// shared constants, types and helper functions of the median filter
package mf2d_pkg;

	localparam int PIX_W   = 16;
	localparam int MAX_W   = 1024;
	localparam int MAX_H   = 4096;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 13;
	localparam int OROW_W  = 12;
	localparam int WID_W   = 11;
	localparam int HGT_W   = 13;
	localparam int HALF_W  = 2;
	localparam int NROWS   = 7;
	localparam int R7_W    = 3;
	localparam int WIN_N   = NROWS * NROWS;
	localparam int CNT_W   = 6;
	localparam int SLOT_W  = 23;
	localparam int REG_W   = 13;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_HALF   = 2'd2;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic emit;
		logic filt;
		logic last;
	} ctrl_t;

	function automatic logic [CNT_W-1:0] need_of(input logic [HALF_W-1:0] h);
		logic [CNT_W-1:0] n;
		case (h)
			2'd0: n = 6'd1;
			2'd1: n = 6'd5;
			2'd2: n = 6'd13;
			default: n = 6'd25;
		endcase
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] popcnt(input logic [WIN_N-1:0] v);
		logic [CNT_W-1:0] s;
		s = '0;
		for (int i = 0; i < WIN_N; i++) s = s + CNT_W'(v[i]);
		return s;
	endfunction

	function automatic logic [R7_W-1:0] row_sel(input logic [R7_W-1:0] r7, input int k);
		logic [R7_W:0] t;
		t = {1'b0, r7} + 4'(NROWS) - 4'(k);
		if (t >= 4'(NROWS)) t = t - 4'(NROWS);
		return t[R7_W-1:0];
	endfunction

endpackage

// ===== sv/mf2d_row_ram.sv =====
// one row of the line store: one write port, two registered read ports
module mf2d_row_ram
	import mf2d_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [COL_W-1:0] waddr,
	input  pix_t             wdata,
	input  logic             re,
	input  logic [COL_W-1:0] raddr_a,
	input  logic [COL_W-1:0] raddr_b,
	output pix_t             rdata_a,
	output pix_t             rdata_b
);

	pix_t mem [MAX_W];
	pix_t rdata_a_q;
	pix_t rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) begin
			rdata_a_q <= mem[raddr_a];
			rdata_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ===== sv/mf2d_cell.sv =====
// window cell: holds one pixel, shifts it on, and ranks it against the window
module mf2d_cell
	import mf2d_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                shift,
	input  pix_t                din,
	input  pix_t [WIN_N-1:0]    win,
	input  logic [WIN_N-1:0]    mask,
	input  logic                own_mask,
	input  logic [CNT_W-1:0]    need,
	output pix_t                dout,
	output pix_t                med_val
);

	pix_t             v_q;
	logic [WIN_N-1:0] le_s3;
	logic [WIN_N-1:0] lt_s3;
	pix_t             val_s3;
	logic             own_s3;
	logic             flag_s4;
	pix_t             val_s4;
	logic [WIN_N-1:0] le;
	logic [WIN_N-1:0] lt;

	always_comb begin
		for (int j = 0; j < WIN_N; j++) begin
			le[j] = mask[j] && (win[j] <= v_q);
			lt[j] = mask[j] && (win[j] < v_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_s3  <= 1'b0;
			flag_s4 <= 1'b0;
		end else if (en) begin
			own_s3  <= own_mask;
			flag_s4 <= own_s3 && (popcnt(le_s3) >= need) && (popcnt(lt_s3) < need);
		end
	end

	always_ff @(posedge clk) begin
		if (shift) v_q <= din;
		if (en) begin
			le_s3  <= le;
			lt_s3  <= lt;
			val_s3 <= v_q;
			val_s4 <= val_s3;
		end
	end

	assign dout    = v_q;
	assign med_val = flag_s4 ? val_s4 : '0;

endmodule

// ===== sv/median_filter_2d.sv =====
// top level of the streaming two-dimensional median filter
// Pixels arrive in raster order on the s_ group, one per transfer; s_tuser
// marks a pad transfer. Results leave on the m_ group in raster order:
// m_tdata holds the pixel, m_tuser is set when the pixel is a window median
// and clear for a copied border pixel, m_tlast marks the frame's last pixel.
// The window side is 2h+1, h from the half-window register (0 to 3).
// Result of a position appears h rows plus h pixels of input later; after
// the last pixel of a frame, pad transfers flush the remaining results and
// all position counters then restart for the next frame.
// One pixel is accepted per cycle while s_tready is high; m_tvalid rises when
// the transfer completing a window has passed the line store read at its
// accepting edge, then window shift, rank compare, rank count, output register.
// Seven row memories of 1024 pixels each give a window column per cycle while
// not held, and a 7x7 array of cells ranks all window pixels in parallel.
// Reset clears the counters and pipeline valid bits and loads width 1024,
// height 1024, half window 1; the line store is not cleared.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops in the same cycle.
`include "median_filter_2d_defines.svh"

module median_filter_2d
	import mf2d_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // pixel_in
	input  logic [0:0]       s_tuser,   // is_pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // pixel_out
	output logic [0:0]       m_tuser,   // was_filtered
	output logic             m_tlast
);

	logic [WID_W-1:0]  width_q;
	logic [HGT_W-1:0]  height_q;
	logic [HALF_W-1:0] half_q;
	logic [SLOT_W-1:0] lag;
	logic [WID_W-1:0]  w_eff;
	logic [HGT_W-1:0]  h_eff;

	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [R7_W-1:0]   in_r7_q;
	logic [COL_W-1:0]  out_col_q;
	logic [OROW_W-1:0] out_row_q;
	logic [R7_W-1:0]   out_r7_q;
	logic [SLOT_W-1:0] slot_q;

	logic en, in_active, step, wr, col_wrap, ocol_wrap, emit, filt, last;
	logic [HGT_W-1:0] orow13;
	logic [WID_W-1:0] ocol11;

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	ctrl_t            ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	pix_t             pix_s1;
	logic [R7_W-1:0]  r7_s1, or7_s1;
	pix_t             ctr_s2, ctr_s3, ctr_s4;

	pix_t [NROWS-1:0] rd_col;
	pix_t [NROWS-1:0] rd_ctr;
	pix_t [NROWS-1:0] col;
	pix_t             center;
	pix_t [WIN_N-1:0] win;
	pix_t [WIN_N-1:0] med_v;
	logic [WIN_N-1:0] mask;
	logic [R7_W-1:0]  span;
	logic [CNT_W-1:0] need;
	pix_t             med;

	logic             m_tvalid_q;
	pix_t             m_tdata_q;
	logic             m_tuser_q;
	logic             m_tlast_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
			half_q   <= 2'd1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_wdata[WID_W-1:0];
					REG_HEIGHT: height_q <= cfg_wdata[HGT_W-1:0];
					REG_HALF:   half_q   <= cfg_wdata[HALF_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign w_eff = (width_q == '0) ? 11'd1 : ((width_q > 11'(MAX_W)) ? 11'(MAX_W) : width_q);
	assign h_eff = (height_q == '0) ? 13'd1 : ((height_q > 13'(MAX_H)) ? 13'(MAX_H) : height_q);
	assign lag   = SLOT_W'(w_eff) * SLOT_W'(half_q) + SLOT_W'(half_q);

	// input side and position counters
	assign en        = !m_tvalid_q || m_tready;
	assign s_tready  = en;
	assign in_active = in_row_q < h_eff;
	assign step      = s_tvalid && en && !(in_active && s_tuser[0]);
	assign wr        = step && in_active;
	assign col_wrap  = ({1'b0, in_col_q} + 11'd1) >= w_eff;
	assign emit      = slot_q >= lag;
	assign orow13    = {1'b0, out_row_q};
	assign ocol11    = {1'b0, out_col_q};
	assign ocol_wrap = (ocol11 + 11'd1) >= w_eff;
	assign filt      = (orow13 >= 13'(half_q)) && ((orow13 + 13'(half_q)) < h_eff)
		&& (ocol11 >= 11'(half_q)) && ((ocol11 + 11'(half_q)) < w_eff);
	assign last      = ((orow13 + 13'd1) >= h_eff) && ocol_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_r7_q   <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			out_r7_q  <= '0;
			slot_q    <= '0;
		end else if (step) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				in_r7_q   <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				out_r7_q  <= '0;
				slot_q    <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
					in_r7_q  <= (in_r7_q == 3'(NROWS - 1)) ? '0 : in_r7_q + 3'd1;
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (emit) begin
					if (ocol_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OROW_W'(1);
						out_r7_q  <= (out_r7_q == 3'(NROWS - 1)) ? '0 : out_r7_q + 3'd1;
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// line store
	for (genvar g = 0; g < NROWS; g++) begin : g_row
		mf2d_row_ram u_ram (
			.clk     (clk),
			.we      (wr && (in_r7_q == 3'(g))),
			.waddr   (in_col_q),
			.wdata   (s_tdata),
			.re      (en),
			.raddr_a (in_col_q),
			.raddr_b (out_col_q),
			.rdata_a (rd_col[g]),
			.rdata_b (rd_ctr[g])
		);
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= step;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= '{emit: emit, filt: filt, last: last};
			pix_s1  <= s_tdata;
			r7_s1   <= in_r7_q;
			or7_s1  <= out_r7_q;
			ctrl_s2 <= ctrl_s1;
			ctr_s2  <= center;
			ctrl_s3 <= ctrl_s2;
			ctr_s3  <= ctr_s2;
			ctrl_s4 <= ctrl_s3;
			ctr_s4  <= ctr_s3;
		end
	end

	// newest window column: current pixel on top, older rows from the store
	always_comb begin
		col[0] = pix_s1;
		for (int k = 1; k < NROWS; k++) col[k] = rd_col[row_sel(r7_s1, k)];
	end

	assign center = rd_ctr[or7_s1];
	assign span   = {1'b0, half_q} << 1;
	assign need   = need_of(half_q);

	// window cells, shifting one column per transfer
	for (genvar gk = 0; gk < NROWS; gk++) begin : g_wr
		for (genvar gj = 0; gj < NROWS; gj++) begin : g_wc
			pix_t din;
			if (gj == 0) begin : g_first
				assign din = col[gk];
			end else begin : g_next
				assign din = win[gk * NROWS + gj - 1];
			end
			assign mask[gk * NROWS + gj] = (3'(gk) <= span) && (3'(gj) <= span);
			mf2d_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.shift    (en && vld_s1),
				.din      (din),
				.win      (win),
				.mask     (mask),
				.own_mask (mask[gk * NROWS + gj]),
				.need     (need),
				.dout     (win[gk * NROWS + gj]),
				.med_val  (med_v[gk * NROWS + gj])
			);
		end
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < WIN_N; i++) med = med | med_v[i];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= vld_s4 && ctrl_s4.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= ctrl_s4.filt ? med : ctr_s4;
			m_tuser_q <= ctrl_s4.filt;
			m_tlast_q <= ctrl_s4.last;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;
	assign m_tlast    = m_tlast_q;

	`MF_ASSERT_NXT(a_frame_restart, step && emit && last, slot_q == '0 && in_row_q == '0)
	`MF_ASSERT_NXT(a_stall_hold, !en, $stable(vld_s4) && $stable(m_tvalid_q))
	`MF_ASSERT_NXT(a_out_load, en && vld_s4 && ctrl_s4.emit, m_tvalid)

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for median_filter_2d: directed table, register corner frames, random frames
`timescale 1ns / 100ps

module testbench;
	import mf2d_pkg::*;

	localparam int  LIMIT_CYCLES = 600000;
	localparam int  DRAIN_CYCLES = 12;

	typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PAD} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [IDX_W-1:0] idx;
		logic [REG_W-1:0] val;
		logic             has_exp;
		pix_t             exp_pix;
		logic             exp_filt;
		logic             exp_last;
	} stim_row_t;

	typedef struct {
		pix_t pix;
		logic filt;
		logic last;
	} pixel_res_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [15:0]      s_tdata;   // pixel_in
	logic [0:0]       s_tuser;   // is_pad
	logic             m_tvalid;
	logic             m_tready;
	logic [15:0]      m_tdata;   // pixel_out
	logic [0:0]       m_tuser;   // was_filtered
	logic             m_tlast;

	median_filter_2d uut (.*);

	// filter state mirror
	pix_t             rows_mem [NROWS][MAX_W];
	logic [WID_W-1:0] width_reg;
	logic [HGT_W-1:0] height_reg;
	logic [HALF_W-1:0] half_reg;
	int               in_c, in_r, out_c, out_r;
	bit               frame_done;

	pixel_res_t       pending_px[$];
	int               err_cnt;
	int               cycle_cnt;
	int               burst_left;
	int               hold_left;
	bit               hold_done;
	stim_row_t        dir_rows[$];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int eff_w();
		if (width_reg == 0) return 1;
		return (width_reg > MAX_W) ? MAX_W : int'(width_reg);
	endfunction

	function automatic int eff_h();
		if (height_reg == 0) return 1;
		return (height_reg > MAX_H) ? MAX_H : int'(height_reg);
	endfunction

	function automatic pix_t rank_median(int r, int c, int h);
		pix_t vals[$];
		pix_t v;
		int   k;
		for (int i = r - h; i <= r + h; i++)
			for (int j = c - h; j <= c + h; j++) begin
				v = rows_mem[i % NROWS][j];
				k = vals.size();
				vals = {vals, v};
				while (k > 0 && vals[k-1] > v) begin
					vals[k] = vals[k-1];
					k--;
				end
				vals[k] = v;
			end
		return vals[(vals.size() - 1) / 2];
	endfunction

	// advance the mirror by one accepted transfer
	task automatic filter_step(input pix_t pix, input logic pad, output bit has,
			output pixel_res_t res);
		int      w, hg, h, lag, slot, r, c;
		w = eff_w();
		hg = eff_h();
		h = int'(half_reg);
		lag = h * w + h;
		has = 0;
		if (in_r < hg) begin
			if (pad) return;
			rows_mem[in_r % NROWS][in_c] = pix;
		end
		slot = in_r * w + in_c;
		if (in_c + 1 >= w) begin
			in_c = 0;
			in_r++;
		end else
			in_c++;
		if (slot < lag) return;
		r = out_r;
		c = out_c;
		has = 1;
		res.filt = (r >= h) && (r + h < hg) && (c >= h) && (c + h < w);
		res.pix = res.filt ? rank_median(r, c, h) : rows_mem[r % NROWS][c];
		res.last = (r + 1 >= hg) && (c + 1 >= w);
		if (res.last) begin
			in_c = 0;
			in_r = 0;
			out_c = 0;
			out_r = 0;
			frame_done = 1;
		end else if (c + 1 >= w) begin
			out_c = 0;
			out_r++;
		end else
			out_c++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH: width_reg = val[WID_W-1:0];
			REG_HEIGHT: height_reg = val[HGT_W-1:0];
			REG_HALF: half_reg = val[HALF_W-1:0];
			default: ;
		endcase
	endtask

	// one transfer on the input side; bursts with random gaps
	task automatic send_pixel(input pix_t pix, input logic pad, input bit has_exp = 0,
			input pixel_res_t exp_res = '{default: '0});
		bit         has;
		pixel_res_t res;
		int         gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		s_tuser <= pad;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		filter_step(pix, pad, has, res);
		if (has_exp) pending_px = {pending_px, exp_res};
		else if (has) pending_px = {pending_px, res};
	endtask

	function automatic pix_t rand_pix(bit narrow);
		return narrow ? pix_t'($urandom_range(0, 3)) : pix_t'($urandom);
	endfunction

	task automatic run_frame(input logic [REG_W-1:0] wv, input logic [REG_W-1:0] hv,
			input logic [REG_W-1:0] halfv, input int pad_pct, input bit narrow);
		int n;
		write_reg(REG_WIDTH, wv);
		write_reg(REG_HEIGHT, hv);
		write_reg(REG_HALF, halfv);
		frame_done = 0;
		n = eff_w() * eff_h();
		for (int i = 0; i < n; i++) begin
			while ($urandom_range(0, 99) < pad_pct) send_pixel(rand_pix(narrow), 1'b1);
			send_pixel(rand_pix(narrow), 1'b0);
		end
		while (!frame_done) send_pixel(rand_pix(narrow), $urandom_range(0, 3) != 0);
		s_tvalid <= 1'b0;
	endtask

	function automatic stim_row_t mk(row_kind_t kind, logic [REG_W-1:0] v,
			logic [IDX_W-1:0] idx = REG_WIDTH, logic has_exp = 0, pix_t ep = '0,
			logic ef = 0, logic el = 0);
		stim_row_t s;
		s.kind = kind;
		s.idx = idx;
		s.val = v;
		s.has_exp = has_exp;
		s.exp_pix = ep;
		s.exp_filt = ef;
		s.exp_last = el;
		return s;
	endfunction

	// result side
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && cycle_cnt >= 1500 && s_tvalid) begin
			m_tready <= 1'b0;
			hold_left <= 400;
			hold_done <= 1'b1;
		end else case ((cycle_cnt / 97) % 3)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			default: m_tready <= $urandom_range(0, 9) != 0;
		endcase
	end

	always @(posedge clk) begin
		pixel_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_px.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected transfer: pix %h filt %b last %b",
						m_tdata, m_tuser, m_tlast);
			end else begin
				e = pending_px.pop_front();
				if (m_tdata !== e.pix || m_tuser[0] !== e.filt || m_tlast !== e.last) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: exp pix %h filt %b last %b, got %h %b %b",
							e.pix, e.filt, e.last, m_tdata, m_tuser, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		stim_row_t  row;
		pixel_res_t er;
		int         sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		err_cnt = 0;
		cycle_cnt = 0;
		burst_left = 0;
		hold_left = 0;
		hold_done = 0;
		in_c = 0;
		in_r = 0;
		out_c = 0;
		out_r = 0;
		width_reg = WID_W'(1024);
		height_reg = HGT_W'(1024);
		half_reg = 2'd1;
		foreach (rows_mem[i, j]) rows_mem[i][j] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single pixel frame, no window
		dir_rows = {dir_rows, mk(ROW_CFG, 13'd1, REG_WIDTH)};
		dir_rows = {dir_rows, mk(ROW_CFG, 13'd1, REG_HEIGHT)};
		dir_rows = {dir_rows, mk(ROW_CFG, 13'd0, REG_HALF)};
		dir_rows = {dir_rows, mk(ROW_PIX, 13'h1FFF, , 1, 16'hFFFF, 1, 1)};
		dir_rows = {dir_rows, mk(ROW_PIX, 13'h0, , 1, 16'h0000, 1, 1)};
		// window larger than frame, pad while pixels are due
		dir_rows = {dir_rows, mk(ROW_CFG, 13'd2, REG_WIDTH)};
		dir_rows = {dir_rows, mk(ROW_CFG, 13'd2, REG_HEIGHT)};
		dir_rows = {dir_rows, mk(ROW_CFG, 13'd1, REG_HALF)};
		dir_rows = {dir_rows, mk(ROW_PAD, 13'h0)};
		dir_rows = {dir_rows, mk(ROW_PIX, 13'h5)};
		dir_rows = {dir_rows, mk(ROW_PIX, 13'h6)};
		dir_rows = {dir_rows, mk(ROW_PIX, 13'h7)};
		dir_rows = {dir_rows, mk(ROW_PIX, 13'h8, , 1, 16'h5, 0, 0)};
		dir_rows = {dir_rows, mk(ROW_PIX, 13'h1FFF, , 1, 16'h6, 0, 0)};
		dir_rows = {dir_rows, mk(ROW_PAD, 13'h0, , 1, 16'h7, 0, 0)};
		dir_rows = {dir_rows, mk(ROW_PAD, 13'h0, , 1, 16'h8, 0, 1)};
		// 3x3 frame with one median at the center
		dir_rows = {dir_rows, mk(ROW_CFG, 13'd3, REG_WIDTH)};
		dir_rows = {dir_rows, mk(ROW_CFG, 13'd3, REG_HEIGHT)};
		for (int i = 0; i < 9; i++)
			dir_rows = {dir_rows, mk(ROW_PIX, (i % 2) ? 13'h1FFF : 13'(i))};
		for (int i = 0; i < 4; i++) dir_rows = {dir_rows, mk(ROW_PAD, 13'h0)};

		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			er.pix = row.exp_pix;
			er.filt = row.exp_filt;
			er.last = row.exp_last;
			case (row.kind)
				ROW_CFG: write_reg(row.idx, row.val);
				ROW_PIX: send_pixel(pix_t'(row.val == 13'h1FFF ? 16'hFFFF : row.val),
					1'b0, row.has_exp, er);
				default: send_pixel('0, 1'b1, row.has_exp, er);
			endcase
		end
		s_tvalid <= 1'b0;

		// register corners, out-of-range values included
		run_frame(13'd0, 13'd5, 13'd1, 5, 0);
		run_frame(13'd8, 13'd7, 13'd3, 2, 1);
		run_frame(13'd1, 13'd0, 13'd0, 10, 0);
		run_frame(13'd7, 13'd7, 13'h1FFF, 2, 0);

		sent = 0;
		while (sent < 500) begin
			run_frame(13'($urandom_range(1, 12)), 13'($urandom_range(1, 10)),
				13'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 1));
			sent += eff_w() * eff_h() + int'(half_reg) * (eff_w() + 1);
		end

		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/mf2d_pkg.sv
sv/mf2d_row_ram.sv
sv/mf2d_cell.sv
sv/median_filter_2d.sv
sim/testbench.sv
